// ===== rtl/core/timer_slot_bank_unit_macros.svh =====
// ----------------------------------------------------------------------------
// timer slot bank assertion macros
// shared property shorthands for the timer slot bank modules
// ----------------------------------------------------------------------------
`ifndef TIMER_SLOT_BANK_UNIT_MACROS_SVH
`define TIMER_SLOT_BANK_UNIT_MACROS_SVH

// same-cycle implication
`define TSB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TSB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tsb_pkg.sv =====
// ----------------------------------------------------------------------------
// tsb_pkg
// types and constants shared by the timer slot bank modules
// ----------------------------------------------------------------------------
package tsb_pkg;

  localparam int SLOT_COUNT_DEF = 8;
  localparam int MAX_EVENTS     = 8;
  localparam int DIV_STEPS      = 32;

  localparam logic [7:0]  DEST_ABSENT = 8'd0;
  localparam logic [7:0]  SIG_ABSENT  = 8'd0;
  localparam logic [31:0] HALF32      = 32'h8000_0000;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_START  = 2'd1,
    REQ_CANCEL = 2'd2,
    REQ_QUERY  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    RESP_REPLY = 2'd0,
    RESP_EVENT = 2'd1,
    RESP_EMPTY = 2'd2
  } resp_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REQ,
    ST_RD,
    ST_CHK,
    ST_DIV,
    ST_FIN
  } st_e;

  typedef struct packed {
    logic        periodic;
    logic [7:0]  dest;
    logic [7:0]  signal;
    logic [31:0] payload;
    logic [31:0] deadline;
    logic [31:0] period;
  } slot_rec_t;

  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] rem;
  } div_rsp_t;

endpackage

// ===== rtl/core/tsb_slot_mem.sv =====
// ----------------------------------------------------------------------------
// tsb_slot_mem
// slot record store, one write port and one registered read port
// ----------------------------------------------------------------------------
module tsb_slot_mem #(
  parameter int DEPTH = tsb_pkg::SLOT_COUNT_DEF,
  parameter int AW    = 3
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  tsb_pkg::slot_rec_t  wdata_i,
  input  logic                rd_en_i,
  input  logic [AW-1:0]       raddr_i,
  output tsb_pkg::slot_rec_t  rdata_o
);

  tsb_pkg::slot_rec_t mem_q [DEPTH];
  tsb_pkg::slot_rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/tsb_rem_div.sv =====
// ----------------------------------------------------------------------------
// tsb_rem_div
// restoring divider, one quotient bit a cycle, returns the remainder
// ----------------------------------------------------------------------------
module tsb_rem_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tsb_pkg::div_req_t req_i,
  output tsb_pkg::div_rsp_t rsp_o
);

  localparam int CW = $clog2(tsb_pkg::DIV_STEPS);

  logic [31:0]   num_q, num_d;
  logic [31:0]   den_q, den_d;
  logic [31:0]   rem_q, rem_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [32:0]   trial;

  assign trial = {rem_q, num_q[31]};

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
      cnt_d  = CW'(tsb_pkg::DIV_STEPS - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[30:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = 32'(trial - {1'b0, den_q});
      end else begin
        rem_d = trial[31:0];
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== rtl/core/timer_slot_bank_unit.sv =====
// ----------------------------------------------------------------------------
// timer_slot_bank_unit
// bank of one-shot and periodic timer slots with tick-driven expiry events
// ----------------------------------------------------------------------------
// Requests enter on the in channel (in_valid_i / in_stall_o); results leave on
// the out channel (out_valid_o / out_stall_i) through an output register.
// Start, cancel and query each give one reply word, loaded into the output
// register from the request state once the output register is free.
// A tick walks the slots in order: an inactive slot is skipped, an active
// one takes a memory read, then a compare. An expired periodic slot with a
// nonzero period also runs the remainder divider for its catch-up deadline.
// A tick gives one event word per expiry (at most eight, the last one flagged)
// or a single empty reply. One item is worked on at a time; the next is taken
// once the previous one has produced its last word into the output register.
// Reset clears every slot's active bit at once; slot records live in a memory
// and are only read for active slots. A stalled receiver holds the output
// word and pauses the tick scan at the next word it wants to emit.
// ----------------------------------------------------------------------------
`include "timer_slot_bank_unit_macros.svh"

module timer_slot_bank_unit #(
  parameter int SLOT_COUNT = tsb_pkg::SLOT_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  slot_id_i,
  input  logic [7:0]  dest_code_i,
  input  logic [7:0]  signal_code_i,
  input  logic [31:0] payload_word_i,
  input  logic [31:0] delay_time_i,
  input  logic        repeat_flag_i,
  input  logic [31:0] now_time_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  resp_kind_o,
  output logic        ok_flag_o,
  output logic [2:0]  fired_slot_o,
  output logic [7:0]  event_dest_o,
  output logic [7:0]  event_signal_o,
  output logic [31:0] event_payload_o,
  output logic [31:0] event_time_o,
  output logic        last_flag_o
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int NF_W  = $clog2(tsb_pkg::MAX_EVENTS + 1);

  // captured request
  tsb_pkg::req_e req_q;
  logic [7:0]    slot_q, dest_q, sig_q;
  logic [31:0]   pay_q, delay_q, now_q;
  logic          rep_q;

  tsb_pkg::st_e     state_q, state_d;
  logic [CNT_W-1:0] scan_q, scan_d;
  logic [NF_W-1:0]  nfired_q, nfired_d;
  logic [SLOT_COUNT-1:0] active_q, active_d;
  logic             caseb_q, caseb_d;

  // held event, emitted once the next one (or the scan end) is known
  logic        pend_valid_q, pend_valid_d;
  logic [2:0]  pend_slot_q, pend_slot_d;
  logic [7:0]  pend_dest_q, pend_dest_d;
  logic [7:0]  pend_sig_q, pend_sig_d;
  logic [31:0] pend_pay_q, pend_pay_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [1:0]  out_kind_q;
  logic        out_ok_q;
  logic [2:0]  out_slot_q;
  logic [7:0]  out_dest_q, out_sig_q;
  logic [31:0] out_pay_q, out_time_q;
  logic        out_last_q;

  logic        out_load;
  logic [1:0]  out_kind_n;
  logic        out_ok_n;
  logic [2:0]  out_slot_n;
  logic [7:0]  out_dest_n, out_sig_n;
  logic [31:0] out_pay_n, out_time_n;
  logic        out_last_n;
  logic        out_free;

  logic               mem_we, mem_rd_en;
  logic [IDX_W-1:0]   mem_waddr, mem_raddr;
  tsb_pkg::slot_rec_t mem_wdata, rd;

  tsb_pkg::div_req_t div_req;
  tsb_pkg::div_rsp_t div_rsp;

  logic             in_accept;
  logic             in_range;
  logic [IDX_W-1:0] id_idx, scan_idx;
  logic             ok_n;
  logic [31:0]      diff, neg_period, next_deadline;
  logic             reached, small_period;

  assign in_stall_o = (state_q != tsb_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign in_range = {1'b0, slot_q} < 9'(SLOT_COUNT);
  assign id_idx   = slot_q[IDX_W-1:0];
  assign scan_idx = scan_q[IDX_W-1:0];

  // wrap-safe expiry test and catch-up arithmetic
  assign diff         = now_q - rd.deadline;
  assign reached      = !diff[31];
  assign small_period = !rd.period[31] || (rd.period == tsb_pkg::HALF32);
  assign neg_period   = 32'd0 - rd.period;

  // deadline + k*period folded through the division remainder
  always_comb begin
    if (caseb_q) begin
      next_deadline = now_q + tsb_pkg::HALF32 + rd.period + 32'd1 + div_rsp.rem;
    end else begin
      next_deadline = now_q - div_rsp.rem + rd.period;
    end
  end

  always_comb begin
    unique case (req_q)
      tsb_pkg::REQ_START: begin
        ok_n = in_range && (dest_q != tsb_pkg::DEST_ABSENT)
               && (sig_q != tsb_pkg::SIG_ABSENT) && (delay_q != 32'd0);
      end
      tsb_pkg::REQ_CANCEL: ok_n = in_range;
      tsb_pkg::REQ_QUERY:  ok_n = in_range && active_q[id_idx];
      default:             ok_n = 1'b0;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    scan_d       = scan_q;
    nfired_d     = nfired_q;
    active_d     = active_q;
    caseb_d      = caseb_q;
    pend_valid_d = pend_valid_q;
    pend_slot_d  = pend_slot_q;
    pend_dest_d  = pend_dest_q;
    pend_sig_d   = pend_sig_q;
    pend_pay_d   = pend_pay_q;
    out_load     = 1'b0;
    out_kind_n   = tsb_pkg::RESP_REPLY;
    out_ok_n     = 1'b0;
    out_slot_n   = '0;
    out_dest_n   = '0;
    out_sig_n    = '0;
    out_pay_n    = '0;
    out_time_n   = '0;
    out_last_n   = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = scan_idx;
    mem_wdata    = rd;
    mem_rd_en    = 1'b0;
    mem_raddr    = scan_idx;
    div_req      = '0;

    unique case (state_q)
      tsb_pkg::ST_IDLE: begin
        if (in_accept) begin
          scan_d   = '0;
          nfired_d = '0;
          if (tsb_pkg::req_e'(req_type_i) == tsb_pkg::REQ_TICK) begin
            state_d = tsb_pkg::ST_RD;
          end else begin
            state_d = tsb_pkg::ST_REQ;
          end
        end
      end
      tsb_pkg::ST_REQ: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_n = tsb_pkg::RESP_REPLY;
          out_ok_n   = ok_n;
          out_last_n = 1'b1;
          if (ok_n && (req_q == tsb_pkg::REQ_START)) begin
            mem_we             = 1'b1;
            mem_waddr          = id_idx;
            mem_wdata.periodic = rep_q;
            mem_wdata.dest     = dest_q;
            mem_wdata.signal   = sig_q;
            mem_wdata.payload  = pay_q;
            mem_wdata.deadline = now_q + delay_q;
            mem_wdata.period   = delay_q;
            active_d[id_idx]   = 1'b1;
          end else if (ok_n && (req_q == tsb_pkg::REQ_CANCEL)) begin
            active_d[id_idx] = 1'b0;
          end
          state_d = tsb_pkg::ST_IDLE;
        end
      end
      tsb_pkg::ST_RD: begin
        if ((scan_q == CNT_W'(SLOT_COUNT)) || (nfired_q == NF_W'(tsb_pkg::MAX_EVENTS))) begin
          state_d = tsb_pkg::ST_FIN;
        end else if (!active_q[scan_idx]) begin
          scan_d = scan_q + 1'b1;
        end else begin
          mem_rd_en = 1'b1;
          state_d   = tsb_pkg::ST_CHK;
        end
      end
      tsb_pkg::ST_CHK: begin
        if (!reached) begin
          scan_d  = scan_q + 1'b1;
          state_d = tsb_pkg::ST_RD;
        end else if (!pend_valid_q || out_free) begin
          if (pend_valid_q) begin
            out_load   = 1'b1;
            out_kind_n = tsb_pkg::RESP_EVENT;
            out_slot_n = pend_slot_q;
            out_dest_n = pend_dest_q;
            out_sig_n  = pend_sig_q;
            out_pay_n  = pend_pay_q;
            out_time_n = now_q;
          end
          pend_valid_d = 1'b1;
          pend_slot_d  = 3'(scan_idx);
          pend_dest_d  = rd.dest;
          pend_sig_d   = rd.signal;
          pend_pay_d   = rd.payload;
          nfired_d     = nfired_q + 1'b1;
          if (!rd.periodic) begin
            active_d[scan_idx] = 1'b0;
            scan_d             = scan_q + 1'b1;
            state_d            = tsb_pkg::ST_RD;
          end else if (rd.period == 32'd0) begin
            scan_d  = scan_q + 1'b1;
            state_d = tsb_pkg::ST_RD;
          end else begin
            div_req.start = 1'b1;
            caseb_d       = !small_period;
            if (small_period) begin
              div_req.num = diff;
              div_req.den = rd.period;
            end else begin
              div_req.num = tsb_pkg::HALF32 - diff + neg_period - 32'd1;
              div_req.den = neg_period;
            end
            state_d = tsb_pkg::ST_DIV;
          end
        end
      end
      tsb_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          mem_we             = 1'b1;
          mem_wdata.deadline = next_deadline;
          scan_d             = scan_q + 1'b1;
          state_d            = tsb_pkg::ST_RD;
        end
      end
      tsb_pkg::ST_FIN: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_last_n = 1'b1;
          if (pend_valid_q) begin
            out_kind_n = tsb_pkg::RESP_EVENT;
            out_slot_n = pend_slot_q;
            out_dest_n = pend_dest_q;
            out_sig_n  = pend_sig_q;
            out_pay_n  = pend_pay_q;
            out_time_n = now_q;
          end else begin
            out_kind_n = tsb_pkg::RESP_EMPTY;
          end
          pend_valid_d = 1'b0;
          state_d      = tsb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tsb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tsb_pkg::ST_IDLE;
      scan_q       <= '0;
      nfired_q     <= '0;
      active_q     <= '0;
      caseb_q      <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      scan_q       <= scan_d;
      nfired_q     <= nfired_d;
      active_q     <= active_d;
      caseb_q      <= caseb_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q   <= tsb_pkg::req_e'(req_type_i);
      slot_q  <= slot_id_i;
      dest_q  <= dest_code_i;
      sig_q   <= signal_code_i;
      pay_q   <= payload_word_i;
      delay_q <= delay_time_i;
      rep_q   <= repeat_flag_i;
      now_q   <= now_time_i;
    end
    pend_slot_q <= pend_slot_d;
    pend_dest_q <= pend_dest_d;
    pend_sig_q  <= pend_sig_d;
    pend_pay_q  <= pend_pay_d;
    if (out_load) begin
      out_kind_q <= out_kind_n;
      out_ok_q   <= out_ok_n;
      out_slot_q <= out_slot_n;
      out_dest_q <= out_dest_n;
      out_sig_q  <= out_sig_n;
      out_pay_q  <= out_pay_n;
      out_time_q <= out_time_n;
      out_last_q <= out_last_n;
    end
  end

  tsb_slot_mem #(
    .DEPTH (SLOT_COUNT),
    .AW    (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .rd_en_i (mem_rd_en),
    .raddr_i (mem_raddr),
    .rdata_o (rd)
  );

  tsb_rem_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o     = out_valid_q;
  assign resp_kind_o     = out_kind_q;
  assign ok_flag_o       = out_ok_q;
  assign fired_slot_o    = out_slot_q;
  assign event_dest_o    = out_dest_q;
  assign event_signal_o  = out_sig_q;
  assign event_payload_o = out_pay_q;
  assign event_time_o    = out_time_q;
  assign last_flag_o     = out_last_q;

  `TSB_ASSERT_IMP(a_no_rw_same_entry, clk_i, rst_ni, mem_rd_en && mem_we, mem_raddr != mem_waddr, "slot read and write collide")
  `TSB_ASSERT_IMP(a_div_start_idle, clk_i, rst_ni, div_req.start, !div_rsp.busy, "divider restarted while busy")
  `TSB_ASSERT_IMP(a_idle_no_pend, clk_i, rst_ni, state_q == tsb_pkg::ST_IDLE, !pend_valid_q, "event left pending after tick")
  `TSB_ASSERT_IMP(a_empty_no_fire, clk_i, rst_ni, out_load && (out_kind_n == tsb_pkg::RESP_EMPTY), nfired_q == '0, "empty reply after an expiry")
  `TSB_ASSERT_NXT(a_load_shows, clk_i, rst_ni, out_load, out_valid_o, "loaded word not presented")

endmodule

// ===== test/timer_slot_bank_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_slot_bank_checker
// watches both channels of the timer slot bank, keeps its own copy of the
// slot state, predicts the words each request causes and compares them
// ----------------------------------------------------------------------------
module timer_slot_bank_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  slot_id_i,
  input  logic [7:0]  dest_code_i,
  input  logic [7:0]  signal_code_i,
  input  logic [31:0] payload_word_i,
  input  logic [31:0] delay_time_i,
  input  logic        repeat_flag_i,
  input  logic [31:0] now_time_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  resp_kind_i,
  input  logic        ok_flag_i,
  input  logic [2:0]  fired_slot_i,
  input  logic [7:0]  event_dest_i,
  input  logic [7:0]  event_signal_i,
  input  logic [31:0] event_payload_i,
  input  logic [31:0] event_time_i,
  input  logic        last_flag_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int SLOTS = tsb_pkg::SLOT_COUNT_DEF;

  typedef struct packed {
    tsb_pkg::resp_e kind;
    logic           ok;
    logic [2:0]     slot;
    logic [7:0]     dest;
    logic [7:0]     sig;
    logic [31:0]    pay;
    logic [31:0]    stamp;
    logic           last;
  } timer_word_t;

  typedef logic [31:0] field_row_t [8];

  string field_name [8] = '{"resp_kind", "ok_flag", "fired_slot", "event_dest",
                            "event_signal", "event_payload", "event_time", "last_flag"};

  // shadow of the slot bank
  logic        armed     [SLOTS];
  logic        repeating [SLOTS];
  logic [7:0]  dest_of   [SLOTS];
  logic [7:0]  signal_of [SLOTS];
  logic [31:0] payload_of[SLOTS];
  logic [31:0] deadline  [SLOTS];
  logic [31:0] period_of [SLOTS];

  timer_word_t due_words[$];
  int          mismatches = 0;

  // wrap-safe: deadline counts as reached while now - deadline is non-negative
  function automatic logic has_expired(logic [31:0] now, logic [31:0] due);
    logic [31:0] lag;
    lag = now - due;
    return !lag[31];
  endfunction

  // first deadline past now, stepping by whole periods
  function automatic logic [31:0] next_deadline(logic [31:0] now, logic [31:0] due,
                                                logic [31:0] period);
    logic [31:0] lag;
    logic [31:0] back;
    logic [63:0] steps;
    lag = now - due;
    if (period <= tsb_pkg::HALF32) begin
      // each period shrinks the lag; stop once it goes negative
      steps = 64'(lag / period) + 64'd1;
    end else begin
      // a period above half the range moves the deadline back by 2^32 - period
      back  = ~period + 32'd1;
      steps = (64'(tsb_pkg::HALF32) - 64'(lag) + 64'(back) - 64'd1) / 64'(back);
    end
    return due + 32'(steps * 64'(period));
  endfunction

  function automatic field_row_t spread(timer_word_t w);
    field_row_t row;
    row = '{32'(w.kind), 32'(w.ok), 32'(w.slot), 32'(w.dest),
            32'(w.sig), w.pay, w.stamp, 32'(w.last)};
    return row;
  endfunction

  task automatic clear_bank();
    int s;
    for (s = 0; s < SLOTS; s++) begin
      armed[s]      = 1'b0;
      repeating[s]  = 1'b0;
      dest_of[s]    = '0;
      signal_of[s]  = '0;
      payload_of[s] = '0;
      deadline[s]   = '0;
      period_of[s]  = '0;
    end
    due_words.delete();
  endtask

  task automatic predict_request();
    timer_word_t   w;
    tsb_pkg::req_e req;
    logic          hit;
    int            fired;
    int            s;
    req   = tsb_pkg::req_e'(req_type_i);
    hit   = slot_id_i < SLOTS;
    fired = 0;
    w     = '0;
    w.kind = tsb_pkg::RESP_REPLY;
    if (req == tsb_pkg::REQ_TICK) begin
      for (s = 0; s < SLOTS && fired < tsb_pkg::MAX_EVENTS; s++) begin
        if (armed[s] && has_expired(now_time_i, deadline[s])) begin
          w.kind  = tsb_pkg::RESP_EVENT;
          w.ok    = 1'b0;
          w.slot  = 3'(s);
          w.dest  = dest_of[s];
          w.sig   = signal_of[s];
          w.pay   = payload_of[s];
          w.stamp = now_time_i;
          w.last  = 1'b0;
          due_words.push_back(w);
          fired++;
          if (repeating[s]) begin
            deadline[s] = next_deadline(now_time_i, deadline[s], period_of[s]);
          end else begin
            armed[s] = 1'b0;
          end
        end
      end
      if (fired == 0) begin
        w      = '0;
        w.kind = tsb_pkg::RESP_EMPTY;
        w.last = 1'b1;
        due_words.push_back(w);
      end else begin
        due_words[due_words.size() - 1].last = 1'b1;
      end
    end else begin
      case (req)
        tsb_pkg::REQ_START: begin
          if (hit && dest_code_i != tsb_pkg::DEST_ABSENT &&
              signal_code_i != tsb_pkg::SIG_ABSENT && delay_time_i != 32'd0) begin
            armed[slot_id_i]      = 1'b1;
            repeating[slot_id_i]  = repeat_flag_i;
            dest_of[slot_id_i]    = dest_code_i;
            signal_of[slot_id_i]  = signal_code_i;
            payload_of[slot_id_i] = payload_word_i;
            deadline[slot_id_i]   = now_time_i + delay_time_i;
            period_of[slot_id_i]  = delay_time_i;
            w.ok = 1'b1;
          end
        end
        tsb_pkg::REQ_CANCEL: begin
          if (hit) begin
            armed[slot_id_i] = 1'b0;
            w.ok = 1'b1;
          end
        end
        default: begin
          if (hit) begin
            w.ok = armed[slot_id_i];
          end
        end
      endcase
      w.last = 1'b1;
      due_words.push_back(w);
    end
  endtask

  task automatic check_word();
    timer_word_t seen;
    timer_word_t want;
    field_row_t  got_f;
    field_row_t  want_f;
    int          f;
    seen.kind  = tsb_pkg::resp_e'(resp_kind_i);
    seen.ok    = ok_flag_i;
    seen.slot  = fired_slot_i;
    seen.dest  = event_dest_i;
    seen.sig   = event_signal_i;
    seen.pay   = event_payload_i;
    seen.stamp = event_time_i;
    seen.last  = last_flag_i;
    got_f = spread(seen);
    if (due_words.size() == 0) begin
      $display("%0t: word with nothing expected: kind %h slot %h payload %h",
               $time, got_f[0], got_f[2], got_f[5]);
      mismatches++;
    end else begin
      want   = due_words.pop_front();
      want_f = spread(want);
      for (f = 0; f < 8; f++) begin
        if (got_f[f] !== want_f[f]) begin
          $display("%0t: %s expected %h, actual %h", $time, field_name[f], want_f[f],
                   got_f[f]);
          mismatches++;
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_bank();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // a word leaving now belongs to an earlier request, so order is free
      if (in_valid_i && !in_stall_i) begin
        predict_request();
      end
      if (out_valid_i && !out_stall_i) begin
        check_word();
      end
      fail_count_o <= mismatches;
      pending_o    <= due_words.size();
    end
  end

endmodule

// ===== test/timer_slot_bank_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_slot_bank_unit_tb
// drives start, cancel, query and tick requests into the timer slot bank:
// a directed opening, then random traffic under several idle/stall mixes,
// with a checker module predicting and comparing every output word
// ----------------------------------------------------------------------------
module timer_slot_bank_unit_tb;

  localparam int CYCLE_LIMIT = 500000;

  logic        clk;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type      = tsb_pkg::REQ_QUERY;
  logic [7:0]  slot_id       = '0;
  logic [7:0]  dest_code     = '0;
  logic [7:0]  signal_code   = '0;
  logic [31:0] payload_word  = '0;
  logic [31:0] delay_time    = '0;
  logic        repeat_flag   = 1'b0;
  logic [31:0] now_time      = '0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [1:0]  resp_kind;
  logic        ok_flag;
  logic [2:0]  fired_slot;
  logic [7:0]  event_dest;
  logic [7:0]  event_signal;
  logic [31:0] event_payload;
  logic [31:0] event_time;
  logic        last_flag;

  int          fail_count;
  int          pending;
  int          cycles    = 0;
  int          idle_pct  = 0;
  int          stall_pct = 0;
  logic [31:0] clock_ms;

  int idle_tab  [4] = '{0, 85, 0, 7};
  int stall_tab [4] = '{0, 0, 85, 7};

  timer_slot_bank_unit DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .req_type_i      (req_type),
    .slot_id_i       (slot_id),
    .dest_code_i     (dest_code),
    .signal_code_i   (signal_code),
    .payload_word_i  (payload_word),
    .delay_time_i    (delay_time),
    .repeat_flag_i   (repeat_flag),
    .now_time_i      (now_time),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .resp_kind_o     (resp_kind),
    .ok_flag_o       (ok_flag),
    .fired_slot_o    (fired_slot),
    .event_dest_o    (event_dest),
    .event_signal_o  (event_signal),
    .event_payload_o (event_payload),
    .event_time_o    (event_time),
    .last_flag_o     (last_flag)
  );

  timer_slot_bank_checker checker_inst (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .req_type_i      (req_type),
    .slot_id_i       (slot_id),
    .dest_code_i     (dest_code),
    .signal_code_i   (signal_code),
    .payload_word_i  (payload_word),
    .delay_time_i    (delay_time),
    .repeat_flag_i   (repeat_flag),
    .now_time_i      (now_time),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .resp_kind_i     (resp_kind),
    .ok_flag_i       (ok_flag),
    .fired_slot_i    (fired_slot),
    .event_dest_i    (event_dest),
    .event_signal_i  (event_signal),
    .event_payload_i (event_payload),
    .event_time_i    (event_time),
    .last_flag_i     (last_flag),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // one request word; valid stays up until the bank takes it
  task automatic send_item(tsb_pkg::req_e req, logic [7:0] id, logic [7:0] dest,
                           logic [7:0] sig, logic [31:0] pay, logic [31:0] delay,
                           logic rep, logic [31:0] now);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= req;
    slot_id      <= id;
    dest_code    <= dest;
    signal_code  <= sig;
    payload_word <= pay;
    delay_time   <= delay;
    repeat_flag  <= rep;
    now_time     <= now;
    do @(posedge clk); while (in_stall);
  endtask

  // unused fields of a tick carry junk
  task automatic tick_at(logic [31:0] now);
    send_item(tsb_pkg::REQ_TICK, 8'($urandom), 8'($urandom), 8'($urandom), $urandom,
              $urandom, 1'($urandom), now);
  endtask

  task automatic directed_items();
    logic [31:0] t0;
    logic [31:0] t1;
    int          s;
    t0 = 32'hFFFF_FFF0;
    t1 = t0 + 32'd32;
    send_item(tsb_pkg::REQ_QUERY, 8'd0, 8'd0, 8'd0, '0, '0, 1'b0, t0);
    tick_at(t0);
    // rejected starts
    send_item(tsb_pkg::REQ_START, 8'd0, tsb_pkg::DEST_ABSENT, 8'd9, 32'h1, 32'd4, 1'b0, t0);
    send_item(tsb_pkg::REQ_START, 8'd0, 8'd9, tsb_pkg::SIG_ABSENT, 32'h1, 32'd4, 1'b0, t0);
    send_item(tsb_pkg::REQ_START, 8'd0, 8'd9, 8'd9, 32'h1, 32'd0, 1'b0, t0);
    send_item(tsb_pkg::REQ_START, 8'd8, 8'd9, 8'd9, 32'h1, 32'd4, 1'b0, t0);
    send_item(tsb_pkg::REQ_START, 8'd255, 8'd9, 8'd9, 32'h1, 32'd4, 1'b1, t0);
    // deadline wraps past zero
    send_item(tsb_pkg::REQ_START, 8'd0, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'd32, 1'b0, t0);
    send_item(tsb_pkg::REQ_START, 8'd7, 8'd1, 8'd1, 32'h0, 32'd5, 1'b1, t0);
    send_item(tsb_pkg::REQ_QUERY, 8'd0, 8'd0, 8'd0, '0, '0, 1'b0, t0);
    send_item(tsb_pkg::REQ_QUERY, 8'd200, 8'd0, 8'd0, '0, '0, 1'b0, t0);
    send_item(tsb_pkg::REQ_CANCEL, 8'd255, 8'd0, 8'd0, '0, '0, 1'b0, t0);
    send_item(tsb_pkg::REQ_CANCEL, 8'd3, 8'd0, 8'd0, '0, '0, 1'b0, t0);
    tick_at(t0 + 32'd5);
    // periodic slot has to skip several periods
    tick_at(t0 + 32'd31);
    tick_at(t1);
    // periods at and beyond half the time range
    send_item(tsb_pkg::REQ_START, 8'd1, 8'h80, 8'h7F, 32'hA5A5_5A5A, tsb_pkg::HALF32, 1'b1,
              t1 - 32'h7000_0000);
    send_item(tsb_pkg::REQ_START, 8'd2, 8'h7F, 8'h80, 32'h5A5A_A5A5, 32'hFFFF_FFFF, 1'b1, t1);
    for (s = 0; s < 7; s++) begin
      if (s != 1 && s != 2) begin
        send_item(tsb_pkg::REQ_START, 8'(s), 8'(s + 2), 8'(s + 3), $urandom, 32'd1,
                  1'($urandom), t1);
      end
    end
    // every slot expires on one tick
    tick_at(t1 + 32'h4000_0000);
    tick_at(t1 + 32'h8000_0040);
  endtask

  task automatic random_item();
    int          pick;
    int          r;
    logic [7:0]  id;
    logic [7:0]  dest;
    logic [7:0]  sig;
    logic [31:0] delay;
    pick = $urandom_range(0, 99);
    id   = 8'($urandom_range(0, 7));
    dest = 8'($urandom_range(1, 255));
    sig  = 8'($urandom_range(1, 255));
    r    = $urandom_range(0, 9);
    if (r < 7) begin
      delay = 32'($urandom_range(1, 40));
    end else if (r < 8) begin
      delay = tsb_pkg::HALF32 + 32'($urandom_range(0, 2)) - 32'd1;
    end else begin
      delay = $urandom | 32'd1;
    end
    if (pick < 40) begin
      case ($urandom_range(0, 19))
        0: dest = tsb_pkg::DEST_ABSENT;
        1: sig = tsb_pkg::SIG_ABSENT;
        2: delay = 32'd0;
        3: id = 8'($urandom_range(8, 255));
        default: ;
      endcase
      send_item(tsb_pkg::REQ_START, id, dest, sig, $urandom, delay, 1'($urandom), clock_ms);
    end else if (pick < 75) begin
      if ($urandom_range(0, 19) == 0) begin
        clock_ms = clock_ms + $urandom;
      end else begin
        clock_ms = clock_ms + 32'($urandom_range(0, 30));
      end
      tick_at(clock_ms);
    end else if (pick < 85) begin
      if ($urandom_range(0, 4) == 0) begin
        id = 8'($urandom);
      end
      send_item(tsb_pkg::REQ_CANCEL, id, 8'($urandom), 8'($urandom), $urandom, $urandom,
                1'($urandom), $urandom);
    end else if (pick < 92) begin
      id = 8'($urandom_range(0, 9));
      send_item(tsb_pkg::REQ_QUERY, id, 8'($urandom), 8'($urandom), $urandom, $urandom,
                1'($urandom), $urandom);
    end else begin
      // noise: any request, any field, any time
      send_item(tsb_pkg::req_e'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                8'($urandom), $urandom, $urandom, 1'($urandom), $urandom);
    end
  endtask

  initial begin
    int p;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_items();
    clock_ms = $urandom;
    for (p = 0; p < 4; p++) begin
      idle_pct  = idle_tab[p];
      stall_pct = stall_tab[p];
      repeat (21) random_item();
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
